>>> sv/circular_deque_with_key_delete_defines.svh
// Assertion macros shared by the circular deque RTL.
`ifndef CIRCULAR_DEQUE_WITH_KEY_DELETE_DEFINES_SVH
`define CIRCULAR_DEQUE_WITH_KEY_DELETE_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define CDQKD_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define CDQKD_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

>>> sv/cdqkd_pkg.sv
// Package with the codes, field widths and default sizes of the circular deque.
`timescale 1ns / 1ps
package cdqkd_pkg;

    // Default sizes
    localparam int DEPTH_DEF     = 16;
    localparam int KEY_WIDTH_DEF = 32;

    // Fixed field widths of the stream ports
    localparam int MODE_W     = 2;
    localparam int KEY_IN_W   = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;
    localparam int OUT_DATA_W = 8;

    // Operation codes carried on s_tuser
    typedef enum logic [MODE_W-1:0] {
        MODE_INS_HEAD = 2'd0,
        MODE_INS_TAIL = 2'd1,
        MODE_DELETE   = 2'd2
    } mode_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } status_t;

endpackage

>>> sv/circular_deque_with_key_delete.sv
// Circular doubly linked list of keys with insert at head/tail and delete by key.
`timescale 1ns / 1ps
`include "circular_deque_with_key_delete_defines.svh"

// A bounded circular list of up to DEPTH keys. Each input transfer carries an
// operation on s_tuser (insert at head, insert at tail, delete first match) and
// a key on s_tdata; each one yields exactly one result transfer with status,
// entry count and empty flag. One item is worked on at a time: s_tready is high
// only while the block is idle, and the result register lets the next item in
// while the previous result still waits on m_tready. Keys and links live in
// one single-port-write row memory with a registered read, freed slots in a
// small free-slot stack memory. An insert passes ST_POP (for a reused slot),
// ST_INS, then on a non-empty list ST_INS_H, ST_INS_T and ST_INS_HW (skipped
// with one old entry); a full store goes straight to ST_DONE. A delete walks
// from the head up to the entry count and on a hit relinks in ST_DPV/ST_DNX. A
// finished result that finds the output register still waiting on m_tready
// holds the block until it is taken. The walk through the row memory, one
// entry per read, sets the delete time. No clearing pass is needed after reset.
module circular_deque_with_key_delete #(
    parameter int DEPTH     = cdqkd_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = cdqkd_pkg::KEY_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cdqkd_pkg::KEY_IN_W-1:0]   s_tdata,   // [31:0] key
    input  logic [cdqkd_pkg::MODE_W-1:0]     s_tuser,   // [1:0] mode
    // Result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cdqkd_pkg::OUT_DATA_W-1:0] m_tdata    // [1:0] status, [6:2] count,
                                                        // [7] empty_res
);
    import cdqkd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef struct packed {
        logic [KEY_WIDTH-1:0] key;
        logic [AW-1:0]        nxt;
        logic [AW-1:0]        prv;
    } row_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POP,
        ST_INS,
        ST_INS_H,
        ST_INS_T,
        ST_INS_HW,
        ST_WALK,
        ST_DPV,
        ST_DNX,
        ST_DONE
    } state_t;

    // Control and payload registers
    state_t               state_reg,   state_next;
    logic [AW-1:0]        head_reg,    head_next;
    logic [CW-1:0]        count_reg,   count_next;
    logic [CW-1:0]        fresh_reg,   fresh_next;
    logic [CW-1:0]        ftop_reg,    ftop_next;
    logic [CW-1:0]        walk_reg,    walk_next;
    logic                 at_head_reg, at_head_next;
    logic [KEY_WIDTH-1:0] key_reg,     key_next;
    logic [AW-1:0]        slot_reg,    slot_next;
    logic [AW-1:0]        cur_reg,     cur_next;
    logic [AW-1:0]        nx_reg,      nx_next;
    logic [AW-1:0]        pv_reg,      pv_next;
    logic [AW-1:0]        tail_reg,    tail_next;
    row_t                 hrow_reg,    hrow_next;
    status_t              status_reg,  status_next;
    logic                 m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    // Memory ports
    row_t                 row_mem [DEPTH];
    row_t                 row_rdata;
    row_t                 row_wdata;
    logic                 row_we;
    logic [AW-1:0]        row_waddr;
    logic [AW-1:0]        row_raddr;

    logic [AW-1:0]        fstk_mem [DEPTH];
    logic [AW-1:0]        fstk_rdata;
    logic                 fstk_we;
    logic [AW-1:0]        fstk_waddr;
    logic [AW-1:0]        fstk_raddr;

    logic [KEY_WIDTH-1:0] key_in;
    logic [CW-1:0]        ftop_dec;

    assign key_in   = KEY_WIDTH'(s_tdata);
    assign ftop_dec = ftop_reg - CW'(1);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Row memory: keys and links, registered read
    always_ff @(posedge aclk) begin
        if (row_we) begin
            row_mem[row_waddr] <= row_wdata;
        end
        row_rdata <= row_mem[row_raddr];
    end

    // Free-slot stack memory
    always_ff @(posedge aclk) begin
        if (fstk_we) begin
            fstk_mem[fstk_waddr] <= cur_reg;
        end
        fstk_rdata <= fstk_mem[fstk_raddr];
    end

    // Next-state and memory access logic
    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        fresh_next   = fresh_reg;
        ftop_next    = ftop_reg;
        walk_next    = walk_reg;
        at_head_next = at_head_reg;
        key_next     = key_reg;
        slot_next    = slot_reg;
        cur_next     = cur_reg;
        nx_next      = nx_reg;
        pv_next      = pv_reg;
        tail_next    = tail_reg;
        hrow_next    = hrow_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        m_data_next  = m_data_reg;

        row_we     = 1'b0;
        row_waddr  = slot_reg;
        row_wdata  = '0;
        row_raddr  = head_reg;
        fstk_we    = 1'b0;
        fstk_waddr = ftop_reg[AW-1:0];
        fstk_raddr = ftop_dec[AW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    key_next     = key_in;
                    at_head_next = (s_tuser == MODE_INS_HEAD);
                    case (s_tuser) inside
                        MODE_INS_HEAD, MODE_INS_TAIL: begin
                            if (count_reg == CW'(DEPTH)) begin
                                status_next = STAT_FULL;
                                state_next  = ST_DONE;
                            end else if (ftop_reg != '0) begin
                                // reuse a freed slot, top of stack read now
                                state_next = ST_POP;
                            end else begin
                                slot_next  = fresh_reg[AW-1:0];
                                fresh_next = fresh_reg + CW'(1);
                                state_next = ST_INS;
                            end
                        end
                        MODE_DELETE: begin
                            if (count_reg == '0) begin
                                status_next = STAT_NOT_FOUND;
                                state_next  = ST_DONE;
                            end else begin
                                cur_next   = head_reg;
                                walk_next  = count_reg - CW'(1);
                                row_raddr  = head_reg;
                                state_next = ST_WALK;
                            end
                        end
                        default: begin
                            status_next = STAT_NOT_FOUND;
                            state_next  = ST_DONE;
                        end
                    endcase
                end
            end

            ST_POP: begin
                slot_next  = fstk_rdata;
                ftop_next  = ftop_dec;
                state_next = ST_INS;
            end

            ST_INS: begin
                if (count_reg == '0) begin
                    // first entry links to itself
                    row_we      = 1'b1;
                    row_waddr   = slot_reg;
                    row_wdata   = '{key: key_reg, nxt: slot_reg, prv: slot_reg};
                    head_next   = slot_reg;
                    count_next  = count_reg + CW'(1);
                    status_next = STAT_OK;
                    state_next  = ST_DONE;
                end else begin
                    row_raddr  = head_reg;
                    state_next = ST_INS_H;
                end
            end

            ST_INS_H: begin
                // new row sits between tail and head; fetch the tail row
                tail_next  = row_rdata.prv;
                hrow_next  = row_rdata;
                row_we     = 1'b1;
                row_waddr  = slot_reg;
                row_wdata  = '{key: key_reg, nxt: head_reg, prv: row_rdata.prv};
                row_raddr  = row_rdata.prv;
                state_next = ST_INS_T;
            end

            ST_INS_T: begin
                row_we    = 1'b1;
                row_waddr = tail_reg;
                if (tail_reg == head_reg) begin
                    // single old entry: both of its links point to the new row
                    row_wdata   = '{key: row_rdata.key, nxt: slot_reg, prv: slot_reg};
                    count_next  = count_reg + CW'(1);
                    if (at_head_reg) begin
                        head_next = slot_reg;
                    end
                    status_next = STAT_OK;
                    state_next  = ST_DONE;
                end else begin
                    row_wdata  = '{key: row_rdata.key, nxt: slot_reg, prv: row_rdata.prv};
                    state_next = ST_INS_HW;
                end
            end

            ST_INS_HW: begin
                row_we      = 1'b1;
                row_waddr   = head_reg;
                row_wdata   = '{key: hrow_reg.key, nxt: hrow_reg.nxt, prv: slot_reg};
                count_next  = count_reg + CW'(1);
                if (at_head_reg) begin
                    head_next = slot_reg;
                end
                status_next = STAT_OK;
                state_next  = ST_DONE;
            end

            ST_WALK: begin
                if (row_rdata.key == key_reg) begin
                    nx_next = row_rdata.nxt;
                    pv_next = row_rdata.prv;
                    if (count_reg == CW'(1)) begin
                        // last entry goes; head keeps a stale value
                        fstk_we     = 1'b1;
                        ftop_next   = ftop_reg + CW'(1);
                        count_next  = '0;
                        status_next = STAT_OK;
                        state_next  = ST_DONE;
                    end else begin
                        row_raddr  = row_rdata.prv;
                        state_next = ST_DPV;
                    end
                end else if (walk_reg == '0) begin
                    status_next = STAT_NOT_FOUND;
                    state_next  = ST_DONE;
                end else begin
                    walk_next = walk_reg - CW'(1);
                    cur_next  = row_rdata.nxt;
                    row_raddr = row_rdata.nxt;
                end
            end

            ST_DPV: begin
                row_we    = 1'b1;
                row_waddr = pv_reg;
                if (pv_reg == nx_reg) begin
                    // one survivor: it links to itself
                    row_wdata   = '{key: row_rdata.key, nxt: pv_reg, prv: pv_reg};
                    fstk_we     = 1'b1;
                    ftop_next   = ftop_reg + CW'(1);
                    count_next  = count_reg - CW'(1);
                    if (cur_reg == head_reg) begin
                        head_next = nx_reg;
                    end
                    status_next = STAT_OK;
                    state_next  = ST_DONE;
                end else begin
                    row_wdata  = '{key: row_rdata.key, nxt: nx_reg, prv: row_rdata.prv};
                    row_raddr  = nx_reg;
                    state_next = ST_DNX;
                end
            end

            ST_DNX: begin
                row_we      = 1'b1;
                row_waddr   = nx_reg;
                row_wdata   = '{key: row_rdata.key, nxt: row_rdata.nxt, prv: pv_reg};
                fstk_we     = 1'b1;
                ftop_next   = ftop_reg + CW'(1);
                count_next  = count_reg - CW'(1);
                if (cur_reg == head_reg) begin
                    head_next = nx_reg;
                end
                status_next = STAT_OK;
                state_next  = ST_DONE;
            end

            ST_DONE: begin
                // hand the result to the output register once it is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {(count_reg == '0), COUNT_W'(count_reg), status_reg};
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            fresh_reg   <= '0;
            ftop_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            fresh_reg   <= fresh_next;
            ftop_reg    <= ftop_next;
            m_valid_reg <= m_valid_next;
        end
        walk_reg    <= walk_next;
        at_head_reg <= at_head_next;
        key_reg     <= key_next;
        slot_reg    <= slot_next;
        cur_reg     <= cur_next;
        nx_reg      <= nx_next;
        pv_reg      <= pv_next;
        tail_reg    <= tail_next;
        hrow_reg    <= hrow_next;
        status_reg  <= status_next;
        m_data_reg  <= m_data_next;
    end

    // Between items every slot ever handed out is either linked or on the free stack
    `CDQKD_ASSERT_NOW(a_slot_accounting,
                      state_reg != ST_IDLE || count_reg + ftop_reg == fresh_reg, "slot leak")
    `CDQKD_ASSERT_NOW(a_count_bound, count_reg <= CW'(DEPTH), "entry count above depth")
    // The delete walk always makes progress toward its end
    `CDQKD_ASSERT_NEXT(a_walk_progress, state_reg == ST_WALK,
                       state_reg != ST_WALK || walk_reg < $past(walk_reg), "walk stalled")

endmodule

>>> test/cdqkd_checker.sv
// Checker for the circular key deque: tracks the list, predicts each result and compares it.
`timescale 1ns / 1ps

module cdqkd_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [cdqkd_pkg::KEY_IN_W-1:0]   s_tdata,   // [31:0] key
    input  logic [cdqkd_pkg::MODE_W-1:0]     s_tuser,   // [1:0] mode
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [cdqkd_pkg::OUT_DATA_W-1:0] m_tdata,   // [1:0] status, [6:2] count,
                                                        // [7] empty_res
    output int unsigned                      fail_count,
    output int unsigned                      outstanding
);
    import cdqkd_pkg::*;

    localparam int SLOTS  = DEPTH_DEF;
    localparam int SLOT_W = $clog2(DEPTH_DEF);

    // Result word as it sits on m_tdata, MSB first
    typedef struct packed {
        logic               empty_res;
        logic [COUNT_W-1:0] count;
        status_t            status;
    } list_result_t;

    // Shadow copy of the list
    logic [KEY_IN_W-1:0] slot_key  [SLOTS];
    logic [SLOT_W-1:0]   slot_next [SLOTS];
    logic [SLOT_W-1:0]   slot_prev [SLOTS];
    logic [SLOTS-1:0]    slot_free;
    logic [SLOT_W-1:0]   head_idx;
    logic [COUNT_W-1:0]  n_entries;

    list_result_t awaited[$];

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        if (fail_count < 50)
            $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
        fail_count = fail_count + 1;
    endtask

    // Insert takes the lowest free slot and links it in before the head
    task automatic list_insert(input logic [KEY_IN_W-1:0] k, input logic at_head,
                               output status_t st);
        logic [SLOT_W-1:0] s;
        logic [SLOT_W-1:0] tail;
        logic              got_slot;
        got_slot = 1'b0;
        s = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!got_slot && slot_free[i]) begin
                s = SLOT_W'(i);
                got_slot = 1'b1;
            end
        end
        if (!got_slot) begin
            st = STAT_FULL;
        end else begin
            slot_free[s] = 1'b0;
            slot_key[s] = k;
            if (n_entries == 0) begin
                slot_next[s] = s;
                slot_prev[s] = s;
                head_idx = s;
            end else begin
                tail = slot_prev[head_idx];
                slot_next[s] = head_idx;
                slot_prev[s] = tail;
                slot_next[tail] = s;
                slot_prev[head_idx] = s;
                if (at_head)
                    head_idx = s;
            end
            n_entries = n_entries + 1'b1;
            st = STAT_OK;
        end
    endtask

    // Delete walks from the head and unlinks the first match only
    task automatic list_delete(input logic [KEY_IN_W-1:0] k, output status_t st);
        logic [SLOT_W-1:0] cur;
        logic [SLOT_W-1:0] nx;
        logic [SLOT_W-1:0] pv;
        logic              hit;
        cur = head_idx;
        hit = 1'b0;
        for (int n = 0; n < n_entries; n++) begin
            if (!hit) begin
                if (slot_key[cur] == k) begin
                    hit = 1'b1;
                    nx = slot_next[cur];
                    pv = slot_prev[cur];
                    if (cur == head_idx)
                        head_idx = nx;
                    slot_next[pv] = nx;
                    slot_prev[nx] = pv;
                    slot_free[cur] = 1'b1;
                    n_entries = n_entries - 1'b1;
                end else begin
                    cur = slot_next[cur];
                end
            end
        end
        st = hit ? STAT_OK : STAT_NOT_FOUND;
    endtask

    task automatic apply_list_op(input logic [MODE_W-1:0] op, input logic [KEY_IN_W-1:0] k,
                                 output list_result_t res);
        status_t st;
        case (op)
            MODE_INS_HEAD: begin
                list_insert(k, 1'b1, st);
            end
            MODE_INS_TAIL: begin
                list_insert(k, 1'b0, st);
            end
            MODE_DELETE: begin
                list_delete(k, st);
            end
            default: begin
                st = STAT_NOT_FOUND;
            end
        endcase
        res.status    = st;
        res.count     = n_entries;
        res.empty_res = (n_entries == 0);
    endtask

    // Result side first: a result at this edge always belongs to an older transfer
    always @(posedge aclk) begin : watch
        list_result_t want_r;
        list_result_t got_r;
        if (!aresetn) begin
            slot_free = '1;
            head_idx  = '0;
            n_entries = '0;
            awaited.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got_r = m_tdata;
                if (awaited.size() == 0) begin
                    report_mismatch("result transfer with nothing outstanding", 0,
                                    32'(got_r));
                end else begin
                    want_r = awaited.pop_front();
                    if (got_r.status !== want_r.status)
                        report_mismatch("status", 32'(want_r.status), 32'(got_r.status));
                    if (got_r.count !== want_r.count)
                        report_mismatch("count", 32'(want_r.count), 32'(got_r.count));
                    if (got_r.empty_res !== want_r.empty_res)
                        report_mismatch("empty_res", 32'(want_r.empty_res),
                                        32'(got_r.empty_res));
                end
            end
            if (s_tvalid && s_tready) begin
                apply_list_op(s_tuser, s_tdata, want_r);
                awaited.push_back(want_r);
            end
        end
        outstanding <= awaited.size();
    end

endmodule

>>> test/circular_deque_with_key_delete_tb.sv
// Testbench top for the circular key deque: clock, reset, stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module circular_deque_with_key_delete_tb;
    import cdqkd_pkg::*;

    // The fourth mode value is not an operation; the block must answer not-found
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int PHASES     = 6;
    localparam int PHASE_OPS  = 300;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [KEY_IN_W-1:0]   s_tdata  = '0;   // [31:0] key
    logic [MODE_W-1:0]     s_tuser  = '0;   // [1:0] mode
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // [1:0] status, [6:2] count, [7] empty_res

    int unsigned fail_count;
    int unsigned outstanding;

    logic [KEY_IN_W-1:0] key_pool [8];
    logic                tx_calm = 1'b0;
    logic                rx_calm = 1'b0;
    int unsigned         rx_hold = 0;
    int unsigned         rx_cycle = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    circular_deque_with_key_delete u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    cdqkd_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Mostly no gap, sometimes a short one, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 8);
    endfunction

    // Result side stalls; calm stretches keep m_tready high
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 512 == 0)
            rx_calm <= ($urandom_range(3) == 0);
        if (rx_hold != 0) begin
            m_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (!rx_calm && $urandom_range(99) < 30) begin
            m_tready <= 1'b0;
            rx_hold <= pick_gap();
        end else begin
            m_tready <= 1'b1;
        end
    end

    // One transfer on the input channel; valid stays up when the next follows at once
    task automatic send_op(input logic [MODE_W-1:0] op, input logic [KEY_IN_W-1:0] k);
        int unsigned gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= k;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Hold the sender until every outstanding result has been taken
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Keys mostly from a small pool so deletes hit and duplicates occur
    function automatic logic [KEY_IN_W-1:0] pick_key();
        if ($urandom_range(99) < 75)
            return key_pool[$urandom_range(7)];
        else
            return $urandom;
    endfunction

    initial begin
        int unsigned ins_pct;
        int unsigned r;
        logic [MODE_W-1:0] op;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty list, unused mode, duplicates, absent key, head/tail/last delete
        send_op(MODE_DELETE, 32'h0000_0000);
        send_op(MODE_UNUSED, 32'hFFFF_FFFF);
        send_op(MODE_INS_HEAD, 32'h0000_0000);
        send_op(MODE_INS_TAIL, 32'hFFFF_FFFF);
        send_op(MODE_INS_HEAD, 32'h0000_0000);
        send_op(MODE_DELETE, 32'h1234_5678);
        send_op(MODE_DELETE, 32'h0000_0000);
        send_op(MODE_DELETE, 32'hFFFF_FFFF);
        send_op(MODE_UNUSED, 32'h0000_0000);
        send_op(MODE_DELETE, 32'h0000_0000);
        // Fill every slot, then both inserts must be rejected
        for (int i = 0; i < DEPTH_DEF; i++)
            send_op((i % 2 == 0) ? MODE_INS_HEAD : MODE_INS_TAIL, i * 32'h1111_1111);
        send_op(MODE_INS_HEAD, 32'hA5A5_A5A5);
        send_op(MODE_INS_TAIL, 32'h5A5A_5A5A);
        send_op(MODE_DELETE, 32'h7777_7777);
        drain_results();

        // Random phases alternate fill-heavy, drain-heavy and balanced mixes
        for (int p = 0; p < PHASES; p++) begin
            key_pool[0] = 32'h0000_0000;
            key_pool[1] = 32'hFFFF_FFFF;
            for (int j = 2; j < 8; j++)
                key_pool[j] = $urandom;
            case (p % 3)
                0: ins_pct = 72;
                1: ins_pct = 28;
                default: ins_pct = 48;
            endcase
            tx_calm = (p == 2);
            for (int n = 0; n < PHASE_OPS; n++) begin
                r = $urandom_range(99);
                if (r < 3)
                    op = MODE_UNUSED;
                else if (r < 3 + ins_pct)
                    op = $urandom_range(1) ? MODE_INS_HEAD : MODE_INS_TAIL;
                else
                    op = MODE_DELETE;
                send_op(op, pick_key());
            end
            drain_results();
        end
        tx_calm = 1'b0;

        // Let any stray result show up before the verdict
        repeat (60) @(posedge aclk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/cdqkd_pkg.sv
sv/circular_deque_with_key_delete.sv
test/cdqkd_checker.sv
test/circular_deque_with_key_delete_tb.sv
